[design/ptmg_pkg.sv]
// ----------------------------------------------------------------------------
// ptmg_pkg
// Shared constants, register indexes and the exp2 table generator for the
// pixel tone map and gamma pipeline.
// ----------------------------------------------------------------------------
package ptmg_pkg;

    localparam int CHAN_BITS     = 24;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int GAMMA_BITS    = 16;
    localparam int ROWS_BITS     = 13;
    localparam int LOG_STEPS     = 16;
    localparam int EXP_STEPS     = 16;
    localparam int GAMMA_STAGES  = 2 + LOG_STEPS + 2 + EXP_STEPS + 1;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SHOW_OOG    = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_APPLY_GAMMA = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_INV_GAMMA   = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_FRAME_ROWS  = t_cfg_idx'(3);

    localparam logic [GAMMA_BITS-1:0] INV_GAMMA_RST  = 16'd4096;
    localparam logic [ROWS_BITS-1:0]  FRAME_ROWS_RST = 13'd400;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Q0.32 factor 2^(-2^(idx-16)), built by repeated square roots
    function automatic logic [31:0] f_exp_entry(input int idx);
        logic [63:0] t;
        t = f_isqrt(64'd1 << 63);
        for (int j = EXP_STEPS - 2; j >= 0; j--) begin
            if (j >= idx) begin
                t = f_isqrt(t << 32);
            end
        end
        return t[31:0];
    endfunction

endpackage

[design/ptmg_norm_div.sv]
// ----------------------------------------------------------------------------
// ptmg_norm_div
// Pipelined restoring divider: scales one channel by 1.0 / max, one quotient
// bit per stage; passes the channel through when no scaling is needed.
// ----------------------------------------------------------------------------
module ptmg_norm_div #(
    parameter int COLOR_FRAC_BITS = 16,
    localparam int OW = COLOR_FRAC_BITS + 1,
    localparam int XW = (OW > ptmg_pkg::CHAN_BITS) ? OW : ptmg_pkg::CHAN_BITS
) (
    input  logic          i_clk,
    input  logic [XW-1:0] i_c,
    input  logic [XW-1:0] i_mx,
    input  logic          i_norm,
    output logic [OW-1:0] o_q
);

    localparam int RW = XW + 1;

    logic [RW-1:0] r_r  [0:OW-2];
    logic [XW-1:0] r_mx [0:OW-2];
    logic [OW-1:0] r_q  [0:OW-1];
    logic [XW-1:0] r_c  [0:OW-1];
    logic          r_nm [0:OW-1];

    for (genvar j = 0; j < OW; j++) begin : g_step
        logic [RW-1:0] w_r;
        logic [XW-1:0] w_mx;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_r  = RW'(i_c);
            assign w_mx = i_mx;
            always_ff @(posedge i_clk) begin
                r_q[0]  <= OW'(w_ge);
                r_c[0]  <= i_c;
                r_nm[0] <= i_norm;
            end
        end else begin : g_next
            assign w_r  = {r_r[j-1][RW-2:0], 1'b0};
            assign w_mx = r_mx[j-1];
            always_ff @(posedge i_clk) begin
                r_q[j]  <= {r_q[j-1][OW-2:0], w_ge};
                r_c[j]  <= r_c[j-1];
                r_nm[j] <= r_nm[j-1];
            end
        end

        assign w_ge = w_r >= RW'(w_mx);

        if (j < OW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_r[j]  <= w_ge ? (w_r - RW'(w_mx)) : w_r;
                r_mx[j] <= w_mx;
            end
        end
    end

    assign o_q = r_nm[OW-1] ? r_q[OW-1] : OW'(r_c[OW-1]);

endmodule

[design/ptmg_gamma.sv]
// ----------------------------------------------------------------------------
// ptmg_gamma
// Pipelined power unit: log2 by repeated squaring, scale by the exponent,
// exp2 by a chain of table products, one step per stage.
// ----------------------------------------------------------------------------
module ptmg_gamma #(
    parameter int COLOR_FRAC_BITS = 16,
    localparam int OW = COLOR_FRAC_BITS + 1
) (
    input  logic                            i_clk,
    input  logic                            i_enable,
    input  logic [ptmg_pkg::GAMMA_BITS-1:0] i_inv_gamma,
    input  logic [OW-1:0]                   i_x,
    output logic [OW-1:0]                   o_y
);

    localparam int CFB     = COLOR_FRAC_BITS;
    localparam int PW      = $clog2(CFB + 1);
    localparam int NW      = PW + 16;
    localparam int EW      = NW + ptmg_pkg::GAMMA_BITS;
    localparam int KW      = EW - 28;
    localparam int SQ_LAST = 1 + ptmg_pkg::LOG_STEPS;
    localparam int N_ST    = SQ_LAST + 1;
    localparam int E_ST    = N_ST + 1;
    localparam int X0      = E_ST + 1;
    localparam int X_LAST  = E_ST + ptmg_pkg::EXP_STEPS;
    localparam logic [OW-1:0] ONE = {1'b1, {CFB{1'b0}}};

    logic [CFB-1:0] r_x0;
    logic [PW-1:0]  r_p   [0:SQ_LAST];
    logic           r_byp [0:X_LAST];
    logic [OW-1:0]  r_bv  [0:X_LAST];
    logic [31:0]    r_m   [1:SQ_LAST];
    logic [15:0]    r_fr  [1:SQ_LAST];
    logic [NW-1:0]  r_n;
    logic [KW-1:0]  r_k   [E_ST:X_LAST];
    logic [15:0]    r_f   [E_ST:X_LAST-1];
    logic [32:0]    r_y   [X0:X_LAST];
    logic [OW-1:0]  r_out;

    logic [PW-1:0]  w_p;
    logic [4:0]     w_sa;
    logic [PW-1:0]  w_ip;
    logic [NW-1:0]  w_n;
    logic [EW-1:0]  w_e;
    logic [32:0]    w_yk;
    logic [32:0]    w_ysh;

    always_comb begin
        w_p = '0;
        for (int i = 0; i < CFB; i++) begin
            if (i_x[i]) begin
                w_p = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0     <= i_x[CFB-1:0];
        r_p[0]   <= w_p;
        r_byp[0] <= !i_enable || (i_x == '0) || i_x[CFB];
        r_bv[0]  <= i_enable ? ((i_x == '0) ? '0 : ONE) : i_x;
    end

    assign w_sa = 5'd31 - 5'(r_p[0]);

    always_ff @(posedge i_clk) begin
        r_m[1]  <= 32'(r_x0) << w_sa;
        r_fr[1] <= '0;
    end

    for (genvar s = 1; s <= X_LAST; s++) begin : g_carry
        always_ff @(posedge i_clk) begin
            r_byp[s] <= r_byp[s-1];
            r_bv[s]  <= r_bv[s-1];
        end
        if (s <= SQ_LAST) begin : g_p
            always_ff @(posedge i_clk) begin
                r_p[s] <= r_p[s-1];
            end
        end
    end

    for (genvar j = 0; j < ptmg_pkg::LOG_STEPS; j++) begin : g_sq
        localparam int S = 2 + j;
        logic [63:0] w_sq;
        logic [32:0] w_t;
        assign w_sq = 64'(r_m[S-1]) * 64'(r_m[S-1]);
        assign w_t  = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            r_m[S]  <= w_t[32] ? w_t[32:1] : w_t[31:0];
            r_fr[S] <= {r_fr[S-1][14:0], w_t[32]};
        end
    end

    assign w_ip = PW'(CFB) - r_p[SQ_LAST];
    assign w_n  = {w_ip, 16'd0} - NW'(r_fr[SQ_LAST]);

    always_ff @(posedge i_clk) begin
        r_n <= w_n;
    end

    assign w_e = EW'(r_n) * EW'(i_inv_gamma);

    always_ff @(posedge i_clk) begin
        r_k[E_ST] <= w_e[EW-1:28];
        r_f[E_ST] <= w_e[27:12];
    end

    for (genvar i = 0; i < ptmg_pkg::EXP_STEPS; i++) begin : g_exp
        localparam int S = X0 + i;
        localparam logic [31:0] TI = ptmg_pkg::f_exp_entry(i);
        logic [32:0] w_yin;
        logic [64:0] w_pr;
        if (i == 0) begin : g_unit
            assign w_yin = {1'b1, 32'd0};
        end else begin : g_chain
            assign w_yin = r_y[S-1];
        end
        assign w_pr = 65'(w_yin) * 65'(TI);
        always_ff @(posedge i_clk) begin
            r_y[S] <= r_f[S-1][i] ? w_pr[64:32] : w_yin;
            r_k[S] <= r_k[S-1];
        end
        if (S < X_LAST) begin : g_f
            always_ff @(posedge i_clk) begin
                r_f[S] <= r_f[S-1];
            end
        end
    end

    assign w_yk  = (r_k[X_LAST] >= KW'(64)) ? '0 : (r_y[X_LAST] >> r_k[X_LAST][5:0]);
    assign w_ysh = w_yk >> (32 - CFB);

    always_ff @(posedge i_clk) begin
        r_out <= r_byp[X_LAST] ? r_bv[X_LAST] : w_ysh[OW-1:0];
    end

    assign o_y = r_out;

endmodule

[design/pixel_tone_map_gamma.sv]
// ----------------------------------------------------------------------------
// pixel_tone_map_gamma
// Tone maps one traced pixel to an 8-bit display pixel with optional gamma.
// ----------------------------------------------------------------------------
// Takes one pixel per clock: busy stays low, so every start beat is accepted.
// Each pixel passes the capture register, the gamut stage, the divider (one
// quotient bit per stage), the power unit (sixteen squaring and sixteen
// product stages) and the output register, and leaves on o_valid for one
// cycle; the receiver cannot stall. Write the configuration only while no
// pixel is in flight.
// ----------------------------------------------------------------------------
module pixel_tone_map_gamma #(
    parameter int COLOR_FRAC_BITS = 16,
    parameter int COORD_BITS      = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [COORD_BITS-1:0]              i_pixel_row,
    input  logic [COORD_BITS-1:0]              i_pixel_column,
    input  logic [ptmg_pkg::CHAN_BITS-1:0]     i_red_in,
    input  logic [ptmg_pkg::CHAN_BITS-1:0]     i_green_in,
    input  logic [ptmg_pkg::CHAN_BITS-1:0]     i_blue_in,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  ptmg_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [ptmg_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                               o_valid,
    output logic [COORD_BITS-1:0]              o_screen_x,
    output logic [COORD_BITS-1:0]              o_screen_y,
    output logic [7:0]                         o_red_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_blue_out,
    output logic                               o_out_of_frame
);

    localparam int CFB = COLOR_FRAC_BITS;
    localparam int CB  = COORD_BITS;
    localparam int CW  = ptmg_pkg::CHAN_BITS;
    localparam int OW  = CFB + 1;
    localparam int XW  = (OW > CW) ? OW : CW;
    localparam int D   = OW + ptmg_pkg::GAMMA_STAGES;
    localparam int LAT = D + 3;
    localparam int SW  = 2 * CB + 1;
    localparam int YW  = ((CB > ptmg_pkg::ROWS_BITS) ? CB : ptmg_pkg::ROWS_BITS) + 1;
    localparam int PW  = OW + 8;
    localparam logic [XW-1:0] ONE_X = XW'(1) << CFB;

    logic                                r_sog;
    logic                                r_ag;
    logic [ptmg_pkg::GAMMA_BITS-1:0]     r_ig;
    logic [ptmg_pkg::ROWS_BITS-1:0]      r_frows;

    logic                                r_va;
    logic [CB-1:0]                       r_a_row;
    logic [CB-1:0]                       r_a_col;
    logic [CW-1:0]                       r_a_c [0:2];

    logic                                r_vb;
    logic [XW-1:0]                       r_b_c [0:2];
    logic [XW-1:0]                       r_b_mx;
    logic                                r_b_norm;
    logic [SW-1:0]                       r_b_side;

    logic                                r_vd [1:D];
    logic [SW-1:0]                       r_sd [1:D];

    logic                                r_valid;
    logic [CB-1:0]                       r_screen_x;
    logic [CB-1:0]                       r_screen_y;
    logic [7:0]                          r_chan [0:2];
    logic                                r_oof;

    logic [CW-1:0]                       w_mx;
    logic                                w_over;
    logic [YW-1:0]                       w_row_x;
    logic [YW-1:0]                       w_rows_x;
    logic                                w_oof;
    logic [YW-1:0]                       w_ydiff;
    logic [CB-1:0]                       w_y;
    logic [OW-1:0]                       w_dq [0:2];
    logic [OW-1:0]                       w_gy [0:2];
    logic [PW-1:0]                       w_px [0:2];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sog   <= 1'b0;
            r_ag    <= 1'b0;
            r_ig    <= ptmg_pkg::INV_GAMMA_RST;
            r_frows <= ptmg_pkg::FRAME_ROWS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ptmg_pkg::CFG_SHOW_OOG:    r_sog   <= i_cfg_data[0];
                ptmg_pkg::CFG_APPLY_GAMMA: r_ag    <= i_cfg_data[0];
                ptmg_pkg::CFG_INV_GAMMA:   r_ig    <= i_cfg_data[ptmg_pkg::GAMMA_BITS-1:0];
                ptmg_pkg::CFG_FRAME_ROWS:  r_frows <= i_cfg_data[ptmg_pkg::ROWS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // capture beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_row  <= i_pixel_row;
        r_a_col  <= i_pixel_column;
        r_a_c[0] <= i_red_in;
        r_a_c[1] <= i_green_in;
        r_a_c[2] <= i_blue_in;
    end

    // largest channel, gamut decision, row flip
    always_comb begin
        w_mx = r_a_c[0];
        if (r_a_c[1] > w_mx) begin
            w_mx = r_a_c[1];
        end
        if (r_a_c[2] > w_mx) begin
            w_mx = r_a_c[2];
        end
    end

    assign w_over   = XW'(w_mx) > ONE_X;
    assign w_row_x  = YW'(r_a_row);
    assign w_rows_x = YW'(r_frows);
    assign w_oof    = w_row_x >= w_rows_x;
    assign w_ydiff  = w_rows_x - w_row_x - YW'(1);
    assign w_y      = w_oof ? '0 : w_ydiff[CB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            if (r_sog && w_over) begin
                r_b_c[ch] <= (ch == 0) ? ONE_X : '0;
            end else begin
                r_b_c[ch] <= XW'(r_a_c[ch]);
            end
        end
        r_b_mx   <= XW'(w_mx);
        r_b_norm <= !r_sog && w_over;
        r_b_side <= {r_a_col, w_y, w_oof};
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        ptmg_norm_div #(
            .COLOR_FRAC_BITS (CFB)
        ) u_div (
            .i_clk  (i_clk),
            .i_c    (r_b_c[ch]),
            .i_mx   (r_b_mx),
            .i_norm (r_b_norm),
            .o_q    (w_dq[ch])
        );

        ptmg_gamma #(
            .COLOR_FRAC_BITS (CFB)
        ) u_gamma (
            .i_clk       (i_clk),
            .i_enable    (r_ag),
            .i_inv_gamma (r_ig),
            .i_x         (w_dq[ch]),
            .o_y         (w_gy[ch])
        );

        assign w_px[ch] = PW'(w_gy[ch]) * PW'(255);
    end

    // hold coordinates alongside the colour pipeline
    for (genvar k = 1; k <= D; k++) begin : g_delay
        if (k == 1) begin : g_head
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vd[1] <= 1'b0;
                end else begin
                    r_vd[1] <= r_vb;
                end
            end
            always_ff @(posedge i_clk) begin
                r_sd[1] <= r_b_side;
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vd[k] <= 1'b0;
                end else begin
                    r_vd[k] <= r_vd[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vd[D];
        end
    end

    always_ff @(posedge i_clk) begin
        r_screen_x <= r_sd[D][SW-1 -: CB];
        r_screen_y <= r_sd[D][CB:1];
        r_oof      <= r_sd[D][0];
        for (int ch = 0; ch < 3; ch++) begin
            r_chan[ch] <= w_px[ch][CFB +: 8];
        end
    end

    assign o_valid        = r_valid;
    assign o_screen_x     = r_screen_x;
    assign o_screen_y     = r_screen_y;
    assign o_red_out      = r_chan[0];
    assign o_green_out    = r_chan[1];
    assign o_blue_out     = r_chan[2];
    assign o_out_of_frame = r_oof;

    a_oof_zero_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_frame) |-> (o_screen_y == '0))
        else $error("out-of-frame beat with nonzero screen y");

    a_beat_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted beat not delivered on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without an accepted beat");

endmodule
